/* src/apts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apts_pkg
// Shared types and constants of the aging priority tick scheduler.
// ----------------------------------------------------------------------------
package apts_pkg;

  // Operation codes carried on the input tuser
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam int OP_W    = 2;
  localparam int IDX_F_W = 3;
  localparam int VAL_F_W = 16;
  localparam int TC_W    = 4;

  localparam logic [TC_W-1:0] TASK_COUNT_RST = 4'd8;

  // Input tdata layout: entry_index, arrival_time, burst_length
  localparam int IN_DATA_W = 40;
  localparam int IN_IDX_LSB = 0;
  localparam int IN_ARR_LSB = 3;
  localparam int IN_BUR_LSB = 19;

  // Output tdata layout, lowest bit first
  localparam int OUT_DATA_W   = 72;
  localparam int OUT_CHO_LSB  = 0;
  localparam int OUT_IDLE_BIT = 3;
  localparam int OUT_DONE_BIT = 4;
  localparam int OUT_TIME_LSB = 5;
  localparam int OUT_REM_LSB  = 21;
  localparam int OUT_PRI_LSB  = 37;
  localparam int OUT_WAI_LSB  = 53;
  localparam int OUT_USED_W   = 69;

  // Compare results from the shared unit
  typedef struct packed {
    logic ready;   // entry has arrived and still has work
    logic better;  // entry beats the current best candidate
  } cmp_t;

endpackage

/* src/aging_priority_tick_scheduler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aging_priority_tick_scheduler
// Task table scheduler with priority aging, one table entry per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one transaction per operation. in_tuser holds the op (load,
//            tick, read); in_tdata holds entry index, arrival time, burst.
//   out_*  : exactly one result transaction per input transaction, in order.
//   cfg_*  : writes task_count; taken at any time, to be used only while idle.
// Sequence, acceptance to result valid:
//   load, read, unused op : S_EXEC, then S_DONE registers the result
//   tick                  : S_EXEC, S_SCAN over the counted entries, S_DRAIN,
//                           S_FIX, S_FIN, S_DONE (task_count capped at
//                           MAX_TASKS; no S_SCAN or S_DRAIN when it is 0);
//                           the scan reads one entry per cycle through the
//                           single table read port and feeds the shared
//                           compare/increment unit.
// Throughput: one op in flight; in_tready low until its result goes valid.
// Reset (rst_n low, synchronous): table reads as zero, time is zero,
//   task_count is 8, no result pending.
// Stall: a finished result waits in the output register; the next input is
//   taken while it waits, but that op's result holds until the slot frees.
// ----------------------------------------------------------------------------
module aging_priority_tick_scheduler #(
  parameter int MAX_TASKS  = 8,
  parameter int COUNT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input: tdata = {burst_length, arrival_time, entry_index}, zero padded
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [apts_pkg::IN_DATA_W-1:0] in_tdata,
  // Input tuser: op
  input  logic [apts_pkg::OP_W-1:0]      in_tuser,
  // Output: tdata = chosen_task, idle, all_done, time_now, entry_remaining,
  //         entry_priority, entry_waited (lowest first), zero padded
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [apts_pkg::OUT_DATA_W-1:0] out_tdata,
  // Configuration: task_count
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [apts_pkg::TC_W-1:0]      cfg_data
);

  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int CB    = COUNT_BITS;
  localparam int REC_W = 4 * CB;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EXEC  = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_DRAIN = 7'b0001000,
    S_FIX   = 7'b0010000,
    S_FIN   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [apts_pkg::OP_W-1:0]    op_r, op_nxt;
  logic [apts_pkg::IDX_F_W-1:0] idx_r, idx_nxt;
  logic [apts_pkg::VAL_F_W-1:0] arr_r, arr_nxt;
  logic [apts_pkg::VAL_F_W-1:0] bur_r, bur_nxt;
  logic [apts_pkg::TC_W-1:0]    task_count_r, task_count_nxt;
  logic [CB-1:0]                time_r, time_nxt;
  logic [MAX_TASKS-1:0]         nz_r, nz_nxt;
  logic [MAX_TASKS-1:0]         ran_r, ran_nxt;
  logic [MAX_TASKS-1:0]         ready_vec_r, ready_vec_nxt;
  logic [IDX_W-1:0]             issue_r, issue_nxt;
  logic [IDX_W-1:0]             chk_idx_r, chk_idx_nxt;
  logic                         chk_vld_r, chk_vld_nxt;
  logic                         found_r, found_nxt;
  logic [IDX_W-1:0]             best_idx_r, best_idx_nxt;
  logic [CB-1:0]                best_arr_r, best_arr_nxt;
  logic [CB-1:0]                best_rem_r, best_rem_nxt;
  logic [CB-1:0]                best_pri_r, best_pri_nxt;
  logic [CB-1:0]                best_wai_r, best_wai_nxt;
  logic                         best_ran_r, best_ran_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [apts_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic             wr_en, rd_en;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  logic [REC_W-1:0] wr_data, rd_data;
  logic [CB-1:0]    rd_arr, rd_rem, rd_pri, rd_wai;

  logic [CB-1:0]    op_a, op_b, sum_a, sum_b;
  logic             inc_two;
  apts_pkg::cmp_t   cmp;

  logic [CNT_W-1:0] eff;
  logic             work_done;
  logic             idx_ok;
  logic [IDX_W-1:0] idx_a;
  logic             last_issue;

  // Record fields, arrival in the low bits
  assign rd_arr = rd_data[CB-1:0];
  assign rd_rem = rd_data[2*CB-1:CB];
  assign rd_pri = rd_data[3*CB-1:2*CB];
  assign rd_wai = rd_data[4*CB-1:3*CB];

  apts_table #(
    .DEPTH (MAX_TASKS),
    .REC_W (REC_W)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Shared operand selection
  assign op_a    = (state_r == S_FIX) ? best_pri_r : rd_pri;
  assign inc_two = (state_r != S_FIX);
  assign op_b    = (state_r == S_FIN) ? time_r : rd_wai;

  apts_unit #(
    .CB (CB)
  ) u_unit (
    .op_a     (op_a),
    .inc_two  (inc_two),
    .op_b     (op_b),
    .sum_a    (sum_a),
    .sum_b    (sum_b),
    .cur_time (time_r),
    .rec_arr  (rd_arr),
    .rec_rem  (rd_rem),
    .rec_pri  (rd_pri),
    .ran_cur  (ran_r[chk_idx_r]),
    .found    (found_r),
    .best_pri (best_pri_r),
    .best_ran (best_ran_r),
    .cmp      (cmp)
  );

  // Effective task count and completion status
  assign eff = (32'(task_count_r) > MAX_TASKS) ? CNT_W'(MAX_TASKS) : CNT_W'(task_count_r);

  always_comb begin
    work_done = 1'b1;
    for (int i = 0; i < MAX_TASKS; i++) begin
      if ((CNT_W'(i) < eff) && nz_r[i]) begin
        work_done = 1'b0;
      end
    end
  end

  assign idx_ok     = (32'(idx_r) < MAX_TASKS);
  assign idx_a      = IDX_W'(idx_r);
  assign last_issue = (CNT_W'(issue_r) == (eff - CNT_W'(1)));

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Sequencer
  always_comb begin
    logic [MAX_TASKS-1:0] best_hot;

    state_nxt      = state_r;
    op_nxt         = op_r;
    idx_nxt        = idx_r;
    arr_nxt        = arr_r;
    bur_nxt        = bur_r;
    task_count_nxt = task_count_r;
    time_nxt       = time_r;
    nz_nxt         = nz_r;
    ran_nxt        = ran_r;
    ready_vec_nxt  = ready_vec_r;
    issue_nxt      = issue_r;
    chk_idx_nxt    = chk_idx_r;
    chk_vld_nxt    = chk_vld_r;
    found_nxt      = found_r;
    best_idx_nxt   = best_idx_r;
    best_arr_nxt   = best_arr_r;
    best_rem_nxt   = best_rem_r;
    best_pri_nxt   = best_pri_r;
    best_wai_nxt   = best_wai_r;
    best_ran_nxt   = best_ran_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    wr_en          = 1'b0;
    wr_addr        = chk_idx_r;
    wr_data        = {sum_b, sum_a, rd_rem, rd_arr};
    rd_en          = 1'b0;
    rd_addr        = issue_r;
    best_hot       = '0;

    if (cfg_valid) begin
      task_count_nxt = cfg_data;
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    // Evaluate the entry read last cycle
    if (chk_vld_r) begin
      if (cmp.ready) begin
        wr_en                    = 1'b1;
        ready_vec_nxt[chk_idx_r] = 1'b1;
      end
      if (cmp.better) begin
        found_nxt    = 1'b1;
        best_idx_nxt = chk_idx_r;
        best_arr_nxt = rd_arr;
        best_rem_nxt = rd_rem;
        best_pri_nxt = rd_pri;
        best_wai_nxt = rd_wai;
        best_ran_nxt = ran_r[chk_idx_r];
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_tuser;
          idx_nxt   = in_tdata[apts_pkg::IN_IDX_LSB +: apts_pkg::IDX_F_W];
          arr_nxt   = in_tdata[apts_pkg::IN_ARR_LSB +: apts_pkg::VAL_F_W];
          bur_nxt   = in_tdata[apts_pkg::IN_BUR_LSB +: apts_pkg::VAL_F_W];
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (op_r)
          apts_pkg::OP_LOAD: begin
            if (idx_ok) begin
              wr_en          = 1'b1;
              wr_addr        = idx_a;
              wr_data        = {{(2*CB){1'b0}}, CB'(bur_r), CB'(arr_r)};
              ran_nxt[idx_a] = 1'b0;
              nz_nxt[idx_a]  = (CB'(bur_r) != '0);
            end
            state_nxt = S_DONE;
          end
          apts_pkg::OP_TICK: begin
            found_nxt     = 1'b0;
            best_idx_nxt  = '0;
            ready_vec_nxt = '0;
            issue_nxt     = '0;
            state_nxt     = (eff == '0) ? S_FIX : S_SCAN;
          end
          apts_pkg::OP_READ: begin
            rd_en     = 1'b1;
            rd_addr   = idx_a;
            state_nxt = S_DONE;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        rd_en       = 1'b1;
        rd_addr     = issue_r;
        chk_vld_nxt = 1'b1;
        chk_idx_nxt = issue_r;
        issue_nxt   = issue_r + IDX_W'(1);
        if (last_issue) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        chk_vld_nxt = 1'b0;
        state_nxt   = S_FIX;
      end
      S_FIX: begin
        // Winner: one burst unit less, +1 priority, waiting unchanged
        if (found_r) begin
          best_hot[best_idx_r] = 1'b1;
          wr_en                = 1'b1;
          wr_addr              = best_idx_r;
          wr_data              = {best_wai_r, sum_a, best_rem_r - CB'(1), best_arr_r};
          ran_nxt              = (ran_r & ~ready_vec_r) | best_hot;
          nz_nxt[best_idx_r]   = (best_rem_r != CB'(1));
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!work_done) begin
          time_nxt = sum_b;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          if (op_r == apts_pkg::OP_TICK) begin
            out_data_nxt[apts_pkg::OUT_CHO_LSB +: apts_pkg::IDX_F_W] =
              apts_pkg::IDX_F_W'(best_idx_r);
            out_data_nxt[apts_pkg::OUT_IDLE_BIT] = !found_r;
          end
          out_data_nxt[apts_pkg::OUT_DONE_BIT] = work_done;
          out_data_nxt[apts_pkg::OUT_TIME_LSB +: apts_pkg::VAL_F_W] =
            apts_pkg::VAL_F_W'(time_r);
          if ((op_r == apts_pkg::OP_READ) && idx_ok) begin
            out_data_nxt[apts_pkg::OUT_REM_LSB +: apts_pkg::VAL_F_W] =
              apts_pkg::VAL_F_W'(rd_rem);
            out_data_nxt[apts_pkg::OUT_PRI_LSB +: apts_pkg::VAL_F_W] =
              apts_pkg::VAL_F_W'(rd_pri);
            out_data_nxt[apts_pkg::OUT_WAI_LSB +: apts_pkg::VAL_F_W] =
              apts_pkg::VAL_F_W'(rd_wai);
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      task_count_r <= apts_pkg::TASK_COUNT_RST;
      time_r       <= '0;
      nz_r         <= '0;
      ran_r        <= '0;
      chk_vld_r    <= 1'b0;
      found_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      task_count_r <= task_count_nxt;
      time_r       <= time_nxt;
      nz_r         <= nz_nxt;
      ran_r        <= ran_nxt;
      chk_vld_r    <= chk_vld_nxt;
      found_r      <= found_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    idx_r       <= idx_nxt;
    arr_r       <= arr_nxt;
    bur_r       <= bur_nxt;
    ready_vec_r <= ready_vec_nxt;
    issue_r     <= issue_nxt;
    chk_idx_r   <= chk_idx_nxt;
    best_idx_r  <= best_idx_nxt;
    best_arr_r  <= best_arr_nxt;
    best_rem_r  <= best_rem_nxt;
    best_pri_r  <= best_pri_nxt;
    best_wai_r  <= best_wai_nxt;
    best_ran_r  <= best_ran_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule

/* src/apts_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apts_table
// Task record memory: one write port, one registered read port, per-entry
// valid bits so that entries never written read as zero.
// ----------------------------------------------------------------------------
module apts_table #(
  parameter int DEPTH = 8,
  parameter int REC_W = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [REC_W-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [REC_W-1:0]         rd_data
);

  logic [REC_W-1:0] mem_r [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [REC_W-1:0] rd_data_r;
  logic             rd_vld_r;

  // Storage write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  // Valid bits and read tag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

/* src/apts_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apts_unit
// Shared arithmetic unit: two saturating incrementers and the readiness and
// priority comparators used once per scanned entry.
// ----------------------------------------------------------------------------
module apts_unit #(
  parameter int CB = 16
) (
  input  logic [CB-1:0]  op_a,
  input  logic           inc_two,
  input  logic [CB-1:0]  op_b,
  output logic [CB-1:0]  sum_a,
  output logic [CB-1:0]  sum_b,
  input  logic [CB-1:0]  cur_time,
  input  logic [CB-1:0]  rec_arr,
  input  logic [CB-1:0]  rec_rem,
  input  logic [CB-1:0]  rec_pri,
  input  logic           ran_cur,
  input  logic           found,
  input  logic [CB-1:0]  best_pri,
  input  logic           best_ran,
  output apts_pkg::cmp_t cmp
);

  logic [CB:0] wide_a;
  logic [CB:0] wide_b;

  // Saturating adds
  assign wide_a = {1'b0, op_a} + (inc_two ? (CB+1)'(2) : (CB+1)'(1));
  assign wide_b = {1'b0, op_b} + (CB+1)'(1);
  assign sum_a  = wide_a[CB] ? '1 : wide_a[CB-1:0];
  assign sum_b  = wide_b[CB] ? '1 : wide_b[CB-1:0];

  // Ready and ranking; ties favor an entry that did not run last
  always_comb begin
    cmp.ready  = (rec_arr <= cur_time) && (rec_rem != '0);
    cmp.better = cmp.ready &&
                 (!found || (rec_pri > best_pri) ||
                  ((rec_pri == best_pri) && best_ran && !ran_cur));
  end

endmodule

/* src/apts_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apts_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module apts_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [apts_pkg::OUT_DATA_W-1:0] out_tdata
);

  // One op at a time: an accepted transaction drops ready
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("in_tready stayed high after an accepted transaction");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // An idle tick names entry zero and carries no entry counters
  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[apts_pkg::OUT_IDLE_BIT] |->
      out_tdata[2:0] == 3'd0 && out_tdata[68:21] == 48'd0)
    else $error("idle result with nonzero task or counter fields");

endmodule

bind aging_priority_tick_scheduler apts_checker u_apts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the aging priority tick scheduler.
// Load, tick, read and unused operations go in through the input stream.
// Both stream sides take random gaps. Each result is predicted by an untimed
// task table model or set by hand, and compared field by field, in order.
// The run has a short directed table and then phases of random traffic, each
// under its own task_count. A last gap-free tick run keeps three long tasks
// competing so that aging and the ran-last tie break alternate the winners.
// ----------------------------------------------------------------------------
module testbench;

  localparam int          TABLE_DEPTH  = 8;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam int          RANDOM_OPS   = 1100;
  localparam int          IDLE_PCT     = 28;
  localparam int          QUIET_LIMIT  = 4000;
  localparam int          TAIL_CYCLES  = 20;
  localparam int          LONG_TICKS   = 120;
  localparam logic [15:0] CNT_MAX      = 16'hFFFF;

  typedef struct packed {
    logic [2:0]  chosen;
    logic        idle;
    logic        all_done;
    logic [15:0] time_now;
    logic [15:0] remaining;
    logic [15:0] prio;
    logic [15:0] waited;
  } sched_result_t;

  // One operation; fixed marks a hand-written expected result
  typedef struct packed {
    logic [1:0]    op;
    logic [2:0]    idx;
    logic [15:0]   arr;
    logic [15:0]   bur;
    logic          fixed;
    sched_result_t exp;
  } sched_op_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [apts_pkg::IN_DATA_W-1:0]  in_tdata;   // entry_index, arrival_time, burst_length
  logic [apts_pkg::OP_W-1:0]       in_tuser;   // op
  logic                            out_tvalid;
  logic                            out_tready;
  logic [apts_pkg::OUT_DATA_W-1:0] out_tdata;  // chosen, idle, all_done, time, rem, pri, wait
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [apts_pkg::TC_W-1:0]       cfg_data;

  aging_priority_tick_scheduler #(
    .MAX_TASKS (TABLE_DEPTH),
    .COUNT_BITS(16)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Predicted table state
  logic [15:0] arr_q    [TABLE_DEPTH];
  logic [15:0] rem_q    [TABLE_DEPTH];
  logic [15:0] prio_q   [TABLE_DEPTH];
  logic [15:0] wait_q   [TABLE_DEPTH];
  logic        ran_last [TABLE_DEPTH];
  logic [15:0] now_q;
  logic [3:0]  count_q;

  sched_result_t pending_results [$];
  int            op_count [4];
  int            ops_sent;
  int            results_checked;
  int            mismatches;
  int            cfg_writes;
  bit            no_gaps;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Scheduler prediction
  // --------------------------------------------------------------------------
  function automatic logic [15:0] sat_inc(input logic [15:0] a, input int unsigned b);
    int unsigned s;
    s = a + b;
    return (s > CNT_MAX) ? CNT_MAX : 16'(s);
  endfunction

  function automatic int counted_entries();
    return (count_q > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_q);
  endfunction

  function automatic bit work_finished();
    for (int i = 0; i < counted_entries(); i++)
      if (rem_q[i] != 16'd0) return 1'b0;
    return 1'b1;
  endfunction

  function automatic sched_result_t schedule_step(input logic [1:0] op,
                                                  input logic [2:0] idx,
                                                  input logic [15:0] arr,
                                                  input logic [15:0] bur);
    sched_result_t r;
    int            n;
    int            best;
    bit            found;
    r     = '0;
    n     = counted_entries();
    best  = 0;
    found = 1'b0;
    case (op)
      apts_pkg::OP_LOAD: begin
        arr_q[idx]    = arr;
        rem_q[idx]    = bur;
        prio_q[idx]   = 16'd0;
        wait_q[idx]   = 16'd0;
        ran_last[idx] = 1'b0;
      end
      apts_pkg::OP_TICK: begin
        // pick: highest priority, then not-ran-last, then lowest index
        for (int i = 0; i < n; i++) begin
          if (arr_q[i] <= now_q && rem_q[i] != 16'd0) begin
            if (!found) begin
              found = 1'b1;
              best  = i;
            end else if (prio_q[i] > prio_q[best] ||
                         (prio_q[i] == prio_q[best] && ran_last[best] && !ran_last[i])) begin
              best = i;
            end
          end
        end
        if (found) begin
          // age everyone else that was ready
          for (int i = 0; i < n; i++) begin
            if (i != best && arr_q[i] <= now_q && rem_q[i] != 16'd0) begin
              prio_q[i]   = sat_inc(prio_q[i], 2);
              wait_q[i]   = sat_inc(wait_q[i], 1);
              ran_last[i] = 1'b0;
            end
          end
          rem_q[best]    = rem_q[best] - 16'd1;
          prio_q[best]   = sat_inc(prio_q[best], 1);
          ran_last[best] = 1'b1;
          r.chosen       = 3'(best);
        end else begin
          r.idle = 1'b1;
        end
        if (!work_finished()) now_q = sat_inc(now_q, 1);
      end
      apts_pkg::OP_READ: begin
        r.remaining = rem_q[idx];
        r.prio      = prio_q[idx];
        r.waited    = wait_q[idx];
      end
      default: ;
    endcase
    r.all_done = work_finished();
    r.time_now = now_q;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic sched_op_t op_item(input logic [1:0] op, input logic [2:0] idx,
                                        input logic [15:0] arr, input logic [15:0] bur);
    sched_op_t t;
    t     = '0;
    t.op  = op;
    t.idx = idx;
    t.arr = arr;
    t.bur = bur;
    return t;
  endfunction

  function automatic sched_op_t checked_item(input logic [1:0] op, input logic [2:0] idx,
                                             input logic [15:0] arr, input logic [15:0] bur,
                                             input sched_result_t exp);
    sched_op_t t;
    t       = op_item(op, idx, arr, bur);
    t.fixed = 1'b1;
    t.exp   = exp;
    return t;
  endfunction

  // Offer one operation, hold it until taken, then log its expected result
  task automatic send_op(input sched_op_t t);
    logic [apts_pkg::IN_DATA_W-1:0] word;
    sched_result_t                  predicted;
    word = '0;
    word[apts_pkg::IN_IDX_LSB +: apts_pkg::IDX_F_W] = t.idx;
    word[apts_pkg::IN_ARR_LSB +: apts_pkg::VAL_F_W] = t.arr;
    word[apts_pkg::IN_BUR_LSB +: apts_pkg::VAL_F_W] = t.bur;
    while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= t.op;
    in_tdata  <= word;
    do @(posedge clk); while (in_tready !== 1'b1);
    predicted = schedule_step(t.op, t.idx, t.arr, t.bur);
    pending_results.push_back(t.fixed ? t.exp : predicted);
    op_count[t.op]++;
    ops_sent++;
  endtask

  // Sender goes quiet until every outstanding result has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_task_count(input logic [3:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    count_q = value;
    cfg_writes++;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    sched_op_t   dir_rows [$];
    logic [3:0]  cnt;
    logic [2:0]  idx;
    logic [15:0] arr;
    logic [15:0] bur;
    int          eff;
    int          span;
    int          pick;
    int          phase;
    int          long_ticks;

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= apts_pkg::OP_LOAD;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      arr_q[i]    = '0;
      rem_q[i]    = '0;
      prio_q[i]   = '0;
      wait_q[i]   = '0;
      ran_last[i] = 1'b0;
    end
    now_q   = '0;
    count_q = apts_pkg::TASK_COUNT_RST;
    no_gaps = 1'b0;
    phase   = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table; result order: chosen, idle, all_done, time, rem, pri, wait
    dir_rows.push_back(checked_item(apts_pkg::OP_READ, 3'd0, 16'd0, 16'd0,
                                    {3'd0, 1'b0, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0}));
    // tick on an empty table: idle, done, time holds
    dir_rows.push_back(checked_item(apts_pkg::OP_TICK, 3'd0, 16'd0, 16'd0,
                                    {3'd0, 1'b1, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0}));
    dir_rows.push_back(checked_item(OP_UNUSED, 3'd7, CNT_MAX, CNT_MAX,
                                    {3'd0, 1'b0, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0}));
    dir_rows.push_back(checked_item(apts_pkg::OP_LOAD, 3'd7, CNT_MAX, CNT_MAX,
                                    {3'd0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0}));
    // not yet arrived: idle tick, but time moves since work remains
    dir_rows.push_back(checked_item(apts_pkg::OP_TICK, 3'd0, 16'd0, 16'd0,
                                    {3'd0, 1'b1, 1'b0, 16'd1, 16'd0, 16'd0, 16'd0}));
    dir_rows.push_back(checked_item(apts_pkg::OP_LOAD, 3'd0, 16'd0, 16'd1,
                                    {3'd0, 1'b0, 1'b0, 16'd1, 16'd0, 16'd0, 16'd0}));
    dir_rows.push_back(op_item(apts_pkg::OP_LOAD, 3'd1, 16'd0, 16'd3));
    dir_rows.push_back(op_item(apts_pkg::OP_LOAD, 3'd2, 16'd1, 16'd2));
    // equal priorities, ran-last tie break, aging
    repeat (6) dir_rows.push_back(op_item(apts_pkg::OP_TICK, 3'd0, 16'd0, 16'd0));
    dir_rows.push_back(op_item(apts_pkg::OP_READ, 3'd0, 16'd0, 16'd0));
    dir_rows.push_back(op_item(apts_pkg::OP_READ, 3'd1, 16'd0, 16'd0));
    dir_rows.push_back(op_item(apts_pkg::OP_READ, 3'd2, 16'd0, 16'd0));
    dir_rows.push_back(op_item(apts_pkg::OP_LOAD, 3'd3, 16'd0, 16'd0));
    dir_rows.push_back(op_item(apts_pkg::OP_READ, 3'd7, 16'd0, 16'd0));
    dir_rows.push_back(op_item(OP_UNUSED, 3'd0, 16'd0, 16'd0));
    dir_rows.push_back(op_item(apts_pkg::OP_LOAD, 3'd7, 16'd0, 16'd0));
    repeat (3) dir_rows.push_back(op_item(apts_pkg::OP_TICK, 3'd0, 16'd0, 16'd0));
    foreach (dir_rows[i]) send_op(dir_rows[i]);

    // Random phases, each with its own task_count
    while (ops_sent < dir_rows.size() + RANDOM_OPS) begin
      phase++;
      drain_results();
      case (phase)
        1:       cnt = 4'd0;
        2:       cnt = 4'd15;
        3:       cnt = 4'd1;
        4:       cnt = 4'd8;
        default: cnt = 4'($urandom_range(0, 15));
      endcase
      write_task_count(cnt);
      no_gaps = (phase == 5);
      eff     = (cnt > TABLE_DEPTH) ? TABLE_DEPTH : int'(cnt);

      // well-formed start: every counted entry loaded close to the current time
      for (int e = 0; e < eff; e++)
        send_op(op_item(apts_pkg::OP_LOAD, 3'(e), sat_inc(now_q, $urandom_range(0, 3)),
                        16'($urandom_range(1, 5))));

      span = $urandom_range(60, 110);
      for (int k = 0; k < span; k++) begin
        idx  = (eff != 0 && $urandom_range(0, 9) != 0) ? 3'($urandom_range(0, eff - 1))
                                                       : 3'($urandom_range(0, 7));
        pick = $urandom_range(0, 99);
        arr  = (pick < 70) ? sat_inc(now_q, $urandom_range(0, 4)) :
               (pick < 90) ? 16'($urandom) : 16'd0;
        pick = $urandom_range(0, 99);
        bur  = (pick < 75) ? 16'($urandom_range(1, 6)) :
               (pick < 90) ? 16'd0 : 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 18)
          send_op(op_item(apts_pkg::OP_LOAD, idx, arr, bur));
        else if (pick < 70)
          send_op(op_item(apts_pkg::OP_TICK, idx, arr, bur));
        else if (pick < 94)
          send_op(op_item(apts_pkg::OP_READ, idx, arr, bur));
        else
          send_op(op_item(OP_UNUSED, idx, arr, bur));
      end
    end

    // Long tick run: three long tasks compete with no gaps; aging and the
    // ran-last tie break keep rotating the winner.
    drain_results();
    write_task_count(4'd3);
    no_gaps = 1'b1;
    for (int e = 0; e < 3; e++)
      send_op(op_item(apts_pkg::OP_LOAD, 3'(e), 16'd0, CNT_MAX));
    long_ticks = 0;
    while (long_ticks < LONG_TICKS) begin
      send_op(op_item(apts_pkg::OP_TICK, 3'($urandom), 16'($urandom), 16'($urandom)));
      long_ticks++;
      if (long_ticks % 32 == 0)
        send_op(op_item(apts_pkg::OP_READ, 3'($urandom_range(0, 2)), 16'd0, 16'd0));
    end
    repeat (6) send_op(op_item(apts_pkg::OP_TICK, 3'd0, 16'd0, 16'd0));
    for (int e = 0; e < 3; e++)
      send_op(op_item(apts_pkg::OP_READ, 3'(e), 16'd0, 16'd0));
    send_op(op_item(OP_UNUSED, 3'd5, 16'd0, 16'd0));

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Run: %0d loads, %0d ticks, %0d reads, %0d unused ops; %0d task_count writes",
             op_count[apts_pkg::OP_LOAD], op_count[apts_pkg::OP_TICK],
             op_count[apts_pkg::OP_READ], op_count[OP_UNUSED], cfg_writes);
    $display("%0d results compared, %0d field mismatches; long tick run took %0d ticks",
             results_checked, mismatches, long_ticks);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: random backpressure plus a few long holds
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int hold_left;
    int holds_done;
    int hold_at;
    hold_left  = 0;
    holds_done = 0;
    hold_at    = 300;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && holds_done < 3 && results_checked >= hold_at) begin
        hold_left = 120;
        holds_done++;
        hold_at += 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Compare each result transaction against the oldest expectation
  initial begin : result_monitor
    sched_result_t want;
    forever begin
      @(posedge clk);
      if (out_tvalid === 1'b1 && out_tready === 1'b1) begin
        results_checked++;
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, got %h", $time, out_tdata);
        end else begin
          want = pending_results.pop_front();
          check_field("chosen_task", 16'(want.chosen),
                      16'(out_tdata[apts_pkg::OUT_CHO_LSB +: 3]));
          check_field("idle", 16'(want.idle), 16'(out_tdata[apts_pkg::OUT_IDLE_BIT]));
          check_field("all_done", 16'(want.all_done),
                      16'(out_tdata[apts_pkg::OUT_DONE_BIT]));
          check_field("time_now", want.time_now, out_tdata[apts_pkg::OUT_TIME_LSB +: 16]);
          check_field("entry_remaining", want.remaining,
                      out_tdata[apts_pkg::OUT_REM_LSB +: 16]);
          check_field("entry_priority", want.prio, out_tdata[apts_pkg::OUT_PRI_LSB +: 16]);
          check_field("entry_waited", want.waited, out_tdata[apts_pkg::OUT_WAI_LSB +: 16]);
        end
      end
    end
  end

  // Watchdog: any handshake on any channel counts as progress
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no transaction for %0d cycles, %0d results outstanding",
             $time, QUIET_LIMIT, pending_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
